// ===== rtl/core/nfba_pkg.sv =====
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared constants, codes and bit-scan helpers for the next-fit allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam int STORE_UNITS_DEF = 4096;

	// one memory word holds this many used flags
	localparam int WORD_W = 64;
	localparam int WB     = 6;
	localparam int IDX_W  = WB + 1;

	localparam int OP_W     = 1;
	localparam int SIZE_W   = 13;
	localparam int START_W  = 13;
	localparam int STATUS_W = 1;
	localparam int GRANT_W  = 12;

	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK   = 1'b0;
	localparam logic [STATUS_W-1:0] ST_FAIL = 1'b1;

	// index of the lowest set bit, WORD_W when none
	function automatic logic [IDX_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = IDX_W'(WORD_W);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

	// number of ones at the top of the word, counted from the msb down
	function automatic logic [IDX_W-1:0] lead_ones(input logic [WORD_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = IDX_W'(WORD_W);
		for (int i = 0; i < WORD_W; i++) begin
			if (!v[i]) begin
				r = IDX_W'(WORD_W - 1 - i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/nfba_ram.sv =====
// ----------------------------------------------------------------------------
// nfba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfba_ram #(
	parameter int WIDTH = nfba_pkg::WORD_W,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/next_fit_byte_map_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_byte_map_allocator
// Next-fit allocator over a used-flag map held in a word-wide RAM.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (lsb first)                     | tuser
//  s_*     | in  | request_size[12:0], start_unit[25:13] | operation
//  m_*     | out | granted_unit[11:0]                    | status
//
//  the map lives in a RAM of 64-bit words, one flag per unit; each cycle
//  reads one word, so an allocate scans up to ceil(STORE_UNITS/64)+1 words
//  through the read pipeline, then rewrites each word the run spans to
//  mark it; a free rewrites each word it clears. after reset a clearing
//  pass writes every word once before s_tready rises. a result waiting
//  on m_tready does not block the next word from being accepted.
module next_fit_byte_map_allocator #(
	parameter int STORE_UNITS = nfba_pkg::STORE_UNITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [nfba_pkg::S_DATA_W-1:0] s_tdata,  // request_size, start_unit
	input  logic [nfba_pkg::OP_W-1:0]     s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [nfba_pkg::M_DATA_W-1:0] m_tdata,  // granted_unit
	output logic [nfba_pkg::STATUS_W-1:0] m_tuser   // status
);

	import nfba_pkg::*;

	localparam int W     = WORD_W;
	localparam int DEPTH = (STORE_UNITS + W - 1) / W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = AW + WB;
	localparam int CW    = $clog2(STORE_UNITS + 1);
	localparam int SW    = (CW > SIZE_W) ? CW : SIZE_W;
	localparam int KW    = SW + 1;

	localparam logic [AW-1:0] LASTW     = AW'(DEPTH - 1);
	localparam logic [W-1:0]  ONES      = '1;
	localparam logic [W-1:0]  LAST_MASK = ONES >> (W * DEPTH - STORE_UNITS);

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		SCAN,
		MARK,
		FREE,
		RESP
	} state_t;

	typedef enum logic {
		PH_FWD,
		PH_WRAP
	} phase_t;

	state_t state_q;
	phase_t ph_q;
	phase_t ph_s1;

	logic [AW-1:0]  ra_q;
	logic           iss_q;
	logic           first_q;
	logic [EW-1:0]  ptr_q;
	logic [EW-1:0]  su_q;
	logic [EW-1:0]  eu_q;
	logic [SIZE_W-1:0] sz_q;
	logic           small_q;
	logic [2:0]     m_q;
	logic [WB-1:0]  d_q;
	logic [STATUS_W-1:0] st_q;

	logic           vld_s1;
	logic [AW-1:0]  w_s1;
	logic           first_s1;
	logic           last_s1;
	logic           vld_s2;
	logic [W-1:0]   hv_s2;
	logic [AW-1:0]  w_s2;
	logic           last_s2;

	logic [W-1:0]   prev_q;
	logic [CW-1:0]  c_q;

	logic           m_tvalid_q;
	logic [GRANT_W-1:0] gr_q;
	logic [STATUS_W-1:0] mst_q;

	logic           ram_we;
	logic [AW-1:0]  ram_wa;
	logic [W-1:0]   ram_wd;
	logic           ram_re;
	logic [W-1:0]   rdata;

	logic [SIZE_W-1:0]  req_size;
	logic [START_W-1:0] req_start;
	logic [OP_W-1:0]    req_op;
	logic [2:0]         m_in;

	logic [AW-1:0]  pw;
	logic [WB-1:0]  pb;

	logic [W-1:0]   rng;
	logic [W-1:0]   fv;
	logic [W-1:0]   pv;
	logic [CW-1:0]  cin;
	logic [2*W-1:0] win [0:WB];
	logic [2*W-1:0] vsel;
	logic [2*W-1:0] vsh;
	logic [W-1:0]   hs;
	logic [W-1:0]   hb;
	logic [W-1:0]   hv;
	logic [KW-1:0]  diff;
	logic [WB-1:0]  jb;
	logic [CW-1:0]  cnext;

	logic [EW-1:0]  end_u;
	logic [EW-1:0]  start_u;
	logic [EW:0]    nx_u;

	logic [W-1:0]   lom;
	logic [IDX_W-1:0] z;
	logic [W-1:0]   clr;
	logic           fdone;
	logic [WB-1:0]  mlo;
	logic [WB-1:0]  mhi;
	logic [W-1:0]   mk;

	assign req_size  = s_tdata[SIZE_W-1:0];
	assign req_start = s_tdata[SIZE_W+START_W-1:SIZE_W];
	assign req_op    = s_tuser;

	assign pw = ptr_q[EW-1:WB];
	assign pb = ptr_q[WB-1:0];

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(gr_q);
	assign m_tuser  = mst_q;

	// floor(log2(size)) for the window split, only used when size <= 64
	always_comb begin
		m_in = '0;
		for (int i = 0; i <= WB; i++) begin
			if (req_size[i]) begin
				m_in = 3'(i);
			end
		end
	end

	// scan: free flags of the current word against the previous one
	always_comb begin
		rng = ONES;
		if (w_s1 == pw) begin
			rng = (ph_s1 == PH_FWD) ? (ONES << pb) : ~(ONES << pb);
		end
		if (w_s1 == LASTW) begin
			rng = rng & LAST_MASK;
		end
		fv  = ~rdata & rng;
		pv  = first_s1 ? '0 : prev_q;
		cin = first_s1 ? '0 : c_q;

		// win[k] bit i set when 2**k free units end at bit i
		win[0] = {fv, pv};
		for (int k = 0; k < WB; k++) begin
			win[k+1] = win[k] & (win[k] << (1 << k));
		end
		vsel = win[m_q];
		vsh  = vsel << d_q;
		hs   = vsel[2*W-1:W] & vsh[2*W-1:W];

		// long runs only finish on the carry of free units from earlier words
		diff = KW'(sz_q) - KW'(cin) - KW'(1);
		jb   = diff[WB-1:0];
		hb   = '0;
		if ((KW'(cin) < KW'(sz_q)) && (diff < KW'(W))) begin
			if ((~fv & (ONES >> (WB'(W - 1) - jb))) == '0) begin
				hb = W'(1) << jb;
			end
		end
		hv = small_q ? hs : hb;

		if (&fv) begin
			cnext = CW'(KW'(cin) + KW'(W));
		end else begin
			cnext = CW'(lead_ones(fv));
		end
	end

	always_comb begin
		end_u   = {w_s2, WB'(lowest_set(hv_s2))};
		start_u = EW'({1'b0, end_u} + (EW+1)'(1) - (EW+1)'(sz_q));
		nx_u    = {1'b0, end_u} + (EW+1)'(1);
	end

	// free: clear the used flags from the start bit up to the first free one
	always_comb begin
		lom   = (w_s1 == su_q[EW-1:WB]) ? (ONES << su_q[WB-1:0]) : ONES;
		z     = lowest_set(~rdata & lom);
		clr   = lom & ~(ONES << z);
		fdone = (z != IDX_W'(W)) || (w_s1 == LASTW);
	end

	always_comb begin
		mlo = (w_s1 == su_q[EW-1:WB]) ? su_q[WB-1:0] : '0;
		mhi = (w_s1 == eu_q[EW-1:WB]) ? eu_q[WB-1:0] : WB'(W - 1);
		mk  = (ONES << mlo) & (ONES >> (WB'(W - 1) - mhi));
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = w_s1;
		ram_wd = '0;
		ram_re = iss_q && ((state_q == SCAN) || (state_q == MARK) || (state_q == FREE));
		unique case (state_q)
			CLEAR: begin
				ram_we = 1'b1;
				ram_wa = ra_q;
			end
			MARK: begin
				ram_we = vld_s1;
				ram_wd = rdata | mk;
			end
			FREE: begin
				ram_we = vld_s1;
				ram_wd = rdata & ~clr;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	nfba_ram #(
		.WIDTH(W),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.re   (ram_re),
		.raddr(ra_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CLEAR;
			ph_q       <= PH_FWD;
			ph_s1      <= PH_FWD;
			ra_q       <= '0;
			iss_q      <= 1'b0;
			first_q    <= 1'b0;
			ptr_q      <= '0;
			su_q       <= '0;
			eu_q       <= '0;
			sz_q       <= '0;
			small_q    <= 1'b0;
			m_q        <= '0;
			d_q        <= '0;
			st_q       <= ST_OK;
			vld_s1     <= 1'b0;
			w_s1       <= '0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			vld_s2     <= 1'b0;
			hv_s2      <= '0;
			w_s2       <= '0;
			last_s2    <= 1'b0;
			prev_q     <= '0;
			c_q        <= '0;
			m_tvalid_q <= 1'b0;
			gr_q       <= '0;
			mst_q      <= ST_OK;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					ra_q <= ra_q + AW'(1);
					if (ra_q == LASTW) begin
						ra_q    <= '0;
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_tvalid) begin
						su_q <= '0;
						if (req_op == OP_ALLOC) begin
							if ((req_size == '0) || (KW'(req_size) > KW'(STORE_UNITS))) begin
								st_q    <= ST_FAIL;
								state_q <= RESP;
							end else begin
								sz_q    <= req_size;
								small_q <= (req_size <= SIZE_W'(W));
								m_q     <= m_in;
								d_q     <= WB'(req_size - (SIZE_W'(1) << m_in));
								ra_q    <= pw;
								ph_q    <= PH_FWD;
								first_q <= 1'b1;
								iss_q   <= 1'b1;
								state_q <= SCAN;
							end
						end else begin
							if (KW'(req_start) >= KW'(STORE_UNITS)) begin
								st_q    <= ST_FAIL;
								state_q <= RESP;
							end else begin
								su_q    <= EW'(req_start);
								ra_q    <= AW'(req_start >> WB);
								iss_q   <= 1'b1;
								st_q    <= ST_OK;
								state_q <= FREE;
							end
						end
					end
				end
				SCAN: begin
					// forward part from the pointer to the end, then from word 0 back
					if (iss_q) begin
						first_q <= 1'b0;
						if (ph_q == PH_FWD) begin
							if (ra_q == LASTW) begin
								ph_q    <= PH_WRAP;
								ra_q    <= '0;
								first_q <= 1'b1;
							end else begin
								ra_q <= ra_q + AW'(1);
							end
						end else begin
							if (ra_q == pw) begin
								iss_q <= 1'b0;
							end else begin
								ra_q <= ra_q + AW'(1);
							end
						end
					end
					vld_s1   <= iss_q;
					w_s1     <= ra_q;
					ph_s1    <= ph_q;
					first_s1 <= first_q;
					last_s1  <= (ph_q == PH_WRAP) && (ra_q == pw);

					vld_s2 <= vld_s1;
					if (vld_s1) begin
						prev_q  <= fv;
						c_q     <= cnext;
						hv_s2   <= hv;
						w_s2    <= w_s1;
						last_s2 <= last_s1;
					end

					if (vld_s2) begin
						if (|hv_s2) begin
							su_q    <= start_u;
							eu_q    <= end_u;
							ptr_q   <= (nx_u == (EW+1)'(STORE_UNITS)) ? '0 : EW'(nx_u);
							st_q    <= ST_OK;
							ra_q    <= start_u[EW-1:WB];
							iss_q   <= 1'b1;
							vld_s1  <= 1'b0;
							vld_s2  <= 1'b0;
							state_q <= MARK;
						end else if (last_s2) begin
							st_q    <= ST_FAIL;
							iss_q   <= 1'b0;
							vld_s1  <= 1'b0;
							vld_s2  <= 1'b0;
							state_q <= RESP;
						end
					end
				end
				MARK: begin
					if (iss_q) begin
						ra_q <= ra_q + AW'(1);
						if (ra_q == eu_q[EW-1:WB]) begin
							iss_q <= 1'b0;
						end
					end
					vld_s1 <= iss_q;
					w_s1   <= ra_q;
					if (vld_s1 && (w_s1 == eu_q[EW-1:WB])) begin
						vld_s1  <= 1'b0;
						iss_q   <= 1'b0;
						state_q <= RESP;
					end
				end
				FREE: begin
					if (iss_q) begin
						ra_q <= ra_q + AW'(1);
						if (ra_q == LASTW) begin
							iss_q <= 1'b0;
						end
					end
					vld_s1 <= iss_q;
					w_s1   <= ra_q;
					if (vld_s1 && fdone) begin
						su_q    <= '0;
						vld_s1  <= 1'b0;
						iss_q   <= 1'b0;
						state_q <= RESP;
					end
				end
				RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						mst_q      <= st_q;
						gr_q       <= (st_q == ST_OK) ? GRANT_W'(su_q) : '0;
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
